FILE: rtl/core/amr_pkg.sv
// ----------------------------------------------------------------------------
// amr_pkg
// Shared constants and types of the axis mean reducer: register map,
// configuration field widths and the stage tag passed between pipeline parts.
// ----------------------------------------------------------------------------
package amr_pkg;

  localparam int INNER_W  = 11;
  localparam int MIDDLE_W = 16;
  localparam int SCALE_W  = 17;
  localparam int MEAN_W   = 16;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Clamped sum width ahead of the multiplier.
  localparam int CLAMP_W  = 32;
  localparam int PROD_W   = CLAMP_W + SCALE_W + 1;
  localparam int FRAC_W   = 16;

  localparam logic [1:0] REG_INNER  = 2'd0;
  localparam logic [1:0] REG_MIDDLE = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  localparam logic [INNER_W-1:0]  INNER_RESET  = 11'd1;
  localparam logic [MIDDLE_W-1:0] MIDDLE_RESET = 16'd1;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 17'd65536;

  localparam logic signed [63:0] CLAMP_HI = 64'sd2147483647;
  localparam logic signed [63:0] CLAMP_LO = -64'sd2147483648;

  localparam logic signed [PROD_W:0] ROUND_BIAS = (PROD_W + 1)'(32768);
  localparam logic signed [MEAN_W-1:0] MEAN_MAX = 16'sh7fff;
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = 16'sh8000;

  typedef struct packed {
    logic valid;
    logic slice_end;
  } amr_tag_t;

endpackage

FILE: rtl/core/amr_ram.sv
// ----------------------------------------------------------------------------
// amr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module amr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/amr_accum.sv
// ----------------------------------------------------------------------------
// amr_accum
// Column and row counters plus the read-modify-write loop on the column sum
// memory, with forwarding for back-to-back requests to the same column.
// ----------------------------------------------------------------------------
module amr_accum #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 40
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          adv_i,
  input  logic                                          in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0]                 sample_i,
  input  logic [amr_pkg::INNER_W-1:0]                   inner_size_i,
  input  logic [amr_pkg::MIDDLE_W-1:0]                  middle_size_i,
  output amr_pkg::amr_tag_t                             out_tag_o,
  output logic [SUM_BITS-1:0]                           sum_o,
  output logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] col_o
);
  import amr_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int IW = (CW + 2 > INNER_W + 1) ? CW + 2 : INNER_W + 1;
  localparam int MW = MIDDLE_W + 1;

  logic            accept;
  logic [CW-1:0]   col_q, col_d;
  logic [MIDDLE_W-1:0] row_q, row_d;
  logic [IW-1:0]   inner_lim;
  logic [MW-1:0]   middle_lim;
  logic            last_col, last_row;

  logic                s1_valid_q;
  logic [CW-1:0]       s1_col_q;
  logic [SUM_BITS-1:0] s1_sample_q;
  logic                s1_first_q, s1_last_row_q, s1_last_col_q;
  logic                fwd_q;
  logic [SUM_BITS-1:0] fwd_data_q;
  logic [SUM_BITS-1:0] rdata, base, acc;
  logic signed [63:0]  sample_ext;

  amr_tag_t            tag_q;
  logic [SUM_BITS-1:0] sum_q;
  logic [CW-1:0]       col_out_q;

  assign accept = adv_i & in_valid_i;

  // Zero sizes act as one, and the column count is capped at the memory depth.
  always_comb begin
    inner_lim = IW'(inner_size_i);
    if (inner_lim == '0) begin
      inner_lim = IW'(1);
    end else if (inner_lim > IW'(MAX_COLUMNS)) begin
      inner_lim = IW'(MAX_COLUMNS);
    end
    middle_lim = (middle_size_i == '0) ? MW'(1) : MW'(middle_size_i);
  end

  assign last_col = (IW'(col_q) + IW'(1)) >= inner_lim;
  assign last_row = (MW'(row_q) + MW'(1)) >= middle_lim;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + MIDDLE_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign sample_ext = 64'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_valid_i;
      // The memory misses a write landing at the same edge as the read.
      fwd_q      <= s1_valid_q && in_valid_i && (col_q == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_col_q      <= col_q;
      s1_sample_q   <= sample_ext[SUM_BITS-1:0];
      s1_first_q    <= (row_q == '0);
      s1_last_row_q <= last_row;
      s1_last_col_q <= last_col;
      fwd_data_q    <= acc;
    end
  end

  amr_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (adv_i & s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (acc),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  assign base = fwd_q ? fwd_data_q : rdata;
  assign acc  = s1_first_q ? s1_sample_q : base + s1_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q.valid     <= s1_valid_q & s1_last_row_q;
      tag_q.slice_end <= s1_last_col_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q     <= acc;
      col_out_q <= s1_col_q;
    end
  end

  assign out_tag_o = tag_q;
  assign sum_o     = sum_q;
  assign col_o     = col_out_q;

endmodule

FILE: rtl/core/amr_scale.sv
// ----------------------------------------------------------------------------
// amr_scale
// Turns a column sum into a mean: clamp, multiply by the Q1.16 reciprocal,
// round to nearest and saturate to sixteen bits.
// ----------------------------------------------------------------------------
module amr_scale #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SUM_BITS    = 40
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          adv_i,
  input  amr_pkg::amr_tag_t                             in_tag_i,
  input  logic [SUM_BITS-1:0]                           sum_i,
  input  logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] col_i,
  input  logic [amr_pkg::SCALE_W-1:0]                   scale_i,
  output amr_pkg::amr_tag_t                             out_tag_o,
  output logic signed [amr_pkg::MEAN_W-1:0]             mean_o,
  output logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] col_o
);
  import amr_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int QW = PROD_W + 1 - FRAC_W;

  logic signed [63:0]        sum_ext;
  logic signed [CLAMP_W-1:0] clamp_d, clamp_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [PROD_W:0]    rnd;
  logic signed [QW-1:0]      quot;
  amr_tag_t                  tag_a_q, tag_b_q;
  logic [CW-1:0]             col_a_q, col_b_q;

  // Any sum beyond the 32-bit range saturates the mean for every nonzero
  // scale, so clamping there keeps the multiplier narrow.
  assign sum_ext = 64'(signed'(sum_i));

  always_comb begin
    if (sum_ext > CLAMP_HI) begin
      clamp_d = CLAMP_HI[CLAMP_W-1:0];
    end else if (sum_ext < CLAMP_LO) begin
      clamp_d = CLAMP_LO[CLAMP_W-1:0];
    end else begin
      clamp_d = sum_ext[CLAMP_W-1:0];
    end
  end

  assign prod_d = clamp_q * signed'({1'b0, scale_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else if (adv_i) begin
      tag_a_q <= in_tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      clamp_q <= clamp_d;
      col_a_q <= col_i;
      prod_q  <= prod_d;
      col_b_q <= col_a_q;
    end
  end

  // Ties round toward plus infinity through the floor of the biased product.
  assign rnd  = (PROD_W + 1)'(prod_q) + ROUND_BIAS;
  assign quot = signed'(rnd[PROD_W:FRAC_W]);

  always_comb begin
    if (quot > QW'(MEAN_MAX)) begin
      mean_o = MEAN_MAX;
    end else if (quot < QW'(MEAN_MIN)) begin
      mean_o = MEAN_MIN;
    end else begin
      mean_o = quot[MEAN_W-1:0];
    end
  end

  assign out_tag_o = tag_b_q;
  assign col_o     = col_b_q;

endmodule

FILE: rtl/core/axis_mean_reducer.sv
// ----------------------------------------------------------------------------
// axis_mean_reducer
// Mean over the middle axis of a row-major [outer, middle, inner] stream.
// ----------------------------------------------------------------------------
// The block takes one sample request per clock cycle while the sample side
// is not stalled, and emits one mean per column on the last middle row.
// Each sample passes the read-modify-write loop on the column sum memory:
// a registered read, an add, and a write-back, with the just-written sum
// forwarded when the next sample hits the same column. The mean path behind
// it is a clamp stage, a multiply stage and a round-and-saturate step into
// the output register. A second output slot absorbs one mean while the
// output stalls; the sample side stalls only when both slots hold a mean.
// The column sum memory needs no clearing after reset, since the first
// middle row overwrites every column it uses.
// Configuration should be changed only while no request is in flight.
// ----------------------------------------------------------------------------
module axis_mean_reducer #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 40
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          sample_valid_i,
  output logic                                          sample_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]                 sample_i,
  output logic                                          mean_valid_o,
  input  logic                                          mean_stall_i,
  output logic signed [amr_pkg::MEAN_W-1:0]             mean_value_o,
  output logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] column_o,
  output logic                                          slice_end_o,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [amr_pkg::ADDR_W-1:0]                    paddr,
  input  logic [amr_pkg::DATA_W-1:0]                    pwdata,
  output logic [amr_pkg::DATA_W-1:0]                    prdata,
  output logic                                          pready
);
  import amr_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [INNER_W-1:0]  inner_q;
  logic [MIDDLE_W-1:0] middle_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [1:0]          reg_idx;
  logic                cfg_wr;

  logic                adv;
  amr_tag_t            acc_tag, res_tag;
  logic [SUM_BITS-1:0] acc_sum;
  logic [CW-1:0]       acc_col, res_col;
  logic signed [MEAN_W-1:0] res_mean;

  logic                     out_valid_q;
  logic signed [MEAN_W-1:0] out_mean_q;
  logic [CW-1:0]            out_col_q;
  logic                     out_end_q;
  logic                     skid_valid_q;
  logic signed [MEAN_W-1:0] skid_mean_q;
  logic [CW-1:0]            skid_col_q;
  logic                     skid_end_q;
  logic                     out_take, res_valid;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q  <= INNER_RESET;
      middle_q <= MIDDLE_RESET;
      scale_q  <= SCALE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INNER:  inner_q  <= pwdata[INNER_W-1:0];
        REG_MIDDLE: middle_q <= pwdata[MIDDLE_W-1:0];
        REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INNER:  prdata = DATA_W'(inner_q);
      REG_MIDDLE: prdata = DATA_W'(middle_q);
      REG_SCALE:  prdata = DATA_W'(scale_q);
      default:    prdata = '0;
    endcase
  end

  // The whole pipeline holds while the second output slot is occupied.
  assign adv            = ~skid_valid_q;
  assign sample_stall_o = skid_valid_q;

  amr_accum #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (sample_valid_i),
    .sample_i      (sample_i),
    .inner_size_i  (inner_q),
    .middle_size_i (middle_q),
    .out_tag_o     (acc_tag),
    .sum_o         (acc_sum),
    .col_o         (acc_col)
  );

  amr_scale #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SUM_BITS    (SUM_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_tag_i  (acc_tag),
    .sum_i     (acc_sum),
    .col_i     (acc_col),
    .scale_i   (scale_q),
    .out_tag_o (res_tag),
    .mean_o    (res_mean),
    .col_o     (res_col)
  );

  assign out_take  = out_valid_q & ~mean_stall_i;
  assign res_valid = adv & res_tag.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && mean_stall_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_mean_q <= skid_mean_q;
        out_col_q  <= skid_col_q;
        out_end_q  <= skid_end_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && mean_stall_i) begin
        skid_mean_q <= res_mean;
        skid_col_q  <= res_col;
        skid_end_q  <= res_tag.slice_end;
      end else begin
        out_mean_q <= res_mean;
        out_col_q  <= res_col;
        out_end_q  <= res_tag.slice_end;
      end
    end
  end

  assign mean_valid_o = out_valid_q;
  assign mean_value_o = out_mean_q;
  assign column_o     = out_col_q;
  assign slice_end_o  = out_end_q;

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(mean_valid_o && mean_stall_i))
    else $error("second output slot filled without a stalled output");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_stall_o |-> mean_valid_o)
    else $error("sample side stalled while the output slot is empty");

  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_valid_o |-> (32'(column_o) < MAX_COLUMNS))
    else $error("mean column beyond the memory depth");

endmodule
